/* src/gap_pkg.sv */
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants for the grid path search core
// Cell addressing, cost markers and sequencer states.
// ----------------------------------------------------------------------------
package gap_pkg;
	localparam int unsigned CELL_W = 6;
	localparam int unsigned COST_W = 7;
	localparam logic [COST_W-1:0] INF_MARK = 7'd127;
	localparam logic [COST_W-1:0] NO_PRED = 7'd127;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_EXPAND,
		ST_NB_RD,
		ST_NB_WR,
		ST_TRACE_RD,
		ST_TRACE_WAIT,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_OUT
	} gap_state_t;
endpackage

/* src/gap_stream_if.sv */
// ----------------------------------------------------------------------------
// gap_req_if / gap_res_if: valid-ready channels of the path search core
// Request carries start and goal; result carries one path cell.
// ----------------------------------------------------------------------------
interface gap_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] start_row;
	logic [2:0] start_col;
	logic [2:0] goal_row;
	logic [2:0] goal_col;
	modport source (output valid, start_row, start_col, goal_row, goal_col, input ready);
	modport sink (input valid, start_row, start_col, goal_row, goal_col, output ready);
endinterface

interface gap_res_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [2:0] cell_row;
	logic [2:0] cell_col;
	logic [5:0] step_index;
	logic       last;
	modport source (output valid, found, cell_row, cell_col, step_index, last, input ready);
	modport sink (input valid, found, cell_row, cell_col, step_index, last, output ready);
endinterface

/* src/grid_astar_path_search_core.sv */
// A request is taken, then the g and predecessor tables are swept and the start
// cell seeded. Each expansion then scans the open set in f memory, picks and reads
// the best cell and visits up to four neighbours. Trace pushes the path from the
// goal back along predecessors onto a stack, and output pops it start first.
// One request at a time; the f-memory scan dominates each search. A blocked start or
// goal answers in the cycle after the request. Reset clears the map and control state.
// ----------------------------------------------------------------------------
// grid_astar_path_search_core
// A* over a 4-connected grid with memory-held g, f and predecessor tables.
// ----------------------------------------------------------------------------
module grid_astar_path_search_core
	import gap_pkg::*;
#(
	parameter int unsigned GRID_SIDE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	gap_req_if.sink     req,
	gap_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int unsigned NCELL = GRID_SIDE * GRID_SIDE;
	localparam logic [CELL_W:0] NCELL_C = (CELL_W+1)'(NCELL);
	localparam logic [2:0] SIDE_M1 = 3'(GRID_SIDE - 1);

	// configuration
	logic [63:0] map_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? map_q : 64'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= 64'd0;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			map_q <= pwdata;
		end
	end

	// memories: g, predecessor, f, path stack
	logic [COST_W-1:0] g_mem [64];
	logic [COST_W-1:0] p_mem [64];
	logic [COST_W-1:0] f_mem [64];
	logic [CELL_W-1:0] stk_mem [64];
	logic              g_we, f_we, p_we, s_we;
	logic [CELL_W-1:0] g_wa, g_ra, s_wa, s_ra;
	logic [COST_W-1:0] g_wd, p_wd, f_wd;
	logic [CELL_W-1:0] s_wd;
	logic [COST_W-1:0] g_rd_q, p_rd_q, f_rd_q;
	logic [CELL_W-1:0] s_rd_q;

	always_ff @(posedge clk) begin
		if (g_we) g_mem[g_wa] <= g_wd;
		if (p_we) p_mem[g_wa] <= p_wd;
		if (f_we) f_mem[g_wa] <= f_wd;
		if (s_we) stk_mem[s_wa] <= s_wd;
		g_rd_q <= g_mem[g_ra];
		p_rd_q <= p_mem[g_ra];
		f_rd_q <= f_mem[g_ra];
		s_rd_q <= stk_mem[s_ra];
	end

	// control registers
	gap_state_t        st_q, st_d;
	logic [63:0]       open_q, open_d;
	logic [CELL_W:0]   cnt_q, cnt_d;
	logic [CELL_W-1:0] s_q, s_d, gl_q, gl_d, cur_q, cur_d, best_q, best_d;
	logic [COST_W:0]   bestf_q, bestf_d;
	logic [COST_W-1:0] ng_q, ng_d;
	logic [1:0]        dir_q, dir_d;
	logic [CELL_W-1:0] nb_q, nb_d;
	logic [CELL_W:0]   len_q, len_d;
	logic              scanv_q, scanv_d;
	logic              ov_q, ov_d, of_q, of_d, ol_q, ol_d;
	logic [2:0]        orow_q, orow_d, ocol_q, ocol_d;
	logic [CELL_W-1:0] ostep_q, ostep_d;

	function automatic logic [CELL_W-1:0] cidx(input logic [2:0] r, input logic [2:0] c);
		cidx = CELL_W'(r) * CELL_W'(GRID_SIDE) + CELL_W'(c);
	endfunction

	// row from cell index by comparing against the row starts
	function automatic logic [2:0] crow(input logic [CELL_W-1:0] i);
		crow = 3'd0;
		for (int unsigned k = 1; k < 8; k++)
			if (k < GRID_SIDE && i >= CELL_W'(k * GRID_SIDE))
				crow = 3'(k);
	endfunction

	function automatic logic [2:0] ccol(input logic [CELL_W-1:0] i);
		ccol = 3'(i - CELL_W'(CELL_W'(crow(i)) * CELL_W'(GRID_SIDE)));
	endfunction

	function automatic logic [3:0] adist(input logic [2:0] a, input logic [2:0] b);
		adist = (a > b) ? 4'(a - b) : 4'(b - a);
	endfunction

	logic       nb_ok;
	logic [2:0] nr, nc, cr, cc, gr, gcl;
	assign cr  = crow(cur_q);
	assign cc  = ccol(cur_q);
	assign gr  = crow(gl_q);
	assign gcl = ccol(gl_q);

	always_comb begin
		nr = cr;
		nc = cc;
		nb_ok = 1'b1;
		case (dir_q)
			2'd0: begin
				nb_ok = (cr != 3'd0);
				nr = cr - 3'd1;
			end
			2'd1: begin
				nb_ok = (cr != SIDE_M1);
				nr = cr + 3'd1;
			end
			2'd2: begin
				nb_ok = (cc != 3'd0);
				nc = cc - 3'd1;
			end
			default: begin
				nb_ok = (cc != SIDE_M1);
				nc = cc + 3'd1;
			end
		endcase
		nb_ok = nb_ok && map_q[cidx(nr, nc)];
	end

	logic ok_s, ok_g;
	assign ok_s = ({1'b0, req.start_row} < 4'(GRID_SIDE))
		&& ({1'b0, req.start_col} < 4'(GRID_SIDE))
		&& map_q[cidx(req.start_row, req.start_col)];
	assign ok_g = ({1'b0, req.goal_row} < 4'(GRID_SIDE))
		&& ({1'b0, req.goal_col} < 4'(GRID_SIDE))
		&& map_q[cidx(req.goal_row, req.goal_col)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			open_q <= '0;
			cnt_q <= '0;
			s_q <= '0;
			gl_q <= '0;
			cur_q <= '0;
			best_q <= '0;
			bestf_q <= '0;
			ng_q <= '0;
			dir_q <= '0;
			nb_q <= '0;
			len_q <= '0;
			scanv_q <= 1'b0;
			ov_q <= 1'b0;
			of_q <= 1'b0;
			ol_q <= 1'b0;
			orow_q <= '0;
			ocol_q <= '0;
			ostep_q <= '0;
		end else begin
			st_q <= st_d;
			open_q <= open_d;
			cnt_q <= cnt_d;
			s_q <= s_d;
			gl_q <= gl_d;
			cur_q <= cur_d;
			best_q <= best_d;
			bestf_q <= bestf_d;
			ng_q <= ng_d;
			dir_q <= dir_d;
			nb_q <= nb_d;
			len_q <= len_d;
			scanv_q <= scanv_d;
			ov_q <= ov_d;
			of_q <= of_d;
			ol_q <= ol_d;
			orow_q <= orow_d;
			ocol_q <= ocol_d;
			ostep_q <= ostep_d;
		end
	end

	assign req.ready      = (st_q == ST_IDLE) && !ov_q;
	assign res.valid      = ov_q;
	assign res.found      = of_q;
	assign res.cell_row   = orow_q;
	assign res.cell_col   = ocol_q;
	assign res.step_index = ostep_q;
	assign res.last       = ol_q;

	always_comb begin
		st_d = st_q; open_d = open_q; cnt_d = cnt_q; s_d = s_q; gl_d = gl_q;
		cur_d = cur_q; best_d = best_q; bestf_d = bestf_q; ng_d = ng_q;
		dir_d = dir_q; nb_d = nb_q; len_d = len_q; scanv_d = 1'b0;
		ov_d = ov_q; of_d = of_q; ol_d = ol_q; orow_d = orow_q; ocol_d = ocol_q;
		ostep_d = ostep_q;
		g_we = 1'b0; p_we = 1'b0; f_we = 1'b0; s_we = 1'b0;
		g_wa = '0; g_ra = '0; s_wa = '0; s_ra = '0;
		g_wd = INF_MARK; p_wd = NO_PRED; f_wd = '0; s_wd = '0;
		if (ov_q && res.ready) ov_d = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (req.valid && req.ready) begin
					if (!ok_s || !ok_g) begin
						ov_d = 1'b1; of_d = 1'b0; ol_d = 1'b1;
						orow_d = '0; ocol_d = '0; ostep_d = '0;
					end else begin
						s_d = cidx(req.start_row, req.start_col);
						gl_d = cidx(req.goal_row, req.goal_col);
						cnt_d = '0;
						st_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				// sweep g and predecessor, seeding the start cell's g and f, then open it
				g_wa = cnt_q[CELL_W-1:0];
				g_we = 1'b1; p_we = 1'b1;
				if (cnt_q[CELL_W-1:0] == s_q) begin
					g_wd = '0;
					f_we = 1'b1;
					f_wd = COST_W'(adist(crow(s_q), gr) + adist(ccol(s_q), gcl));
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 7'd63) begin
					open_d = 64'd1 << s_q;
					cnt_d = '0;
					bestf_d = 8'hff;
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// walk f memory; compare the previous read
				g_ra = cnt_q[CELL_W-1:0];
				scanv_d = (cnt_q < NCELL_C) && open_q[cnt_q[CELL_W-1:0]];
				if (scanv_q && {1'b0, f_rd_q} < bestf_q) begin
					bestf_d = {1'b0, f_rd_q};
					best_d = cur_q;
				end
				cur_d = cnt_q[CELL_W-1:0];
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == NCELL_C) st_d = ST_SCAN_WAIT;
				if (open_q == 64'd0) begin
					ov_d = 1'b1; of_d = 1'b0; ol_d = 1'b1;
					orow_d = '0; ocol_d = '0; ostep_d = '0;
					st_d = ST_IDLE;
				end
			end
			ST_SCAN_WAIT: begin
				cur_d = best_q;
				g_ra = best_q;
				if (best_q == gl_q) begin
					cur_d = gl_q;
					len_d = '0;
					st_d = ST_TRACE_RD;
				end else begin
					open_d[best_q] = 1'b0;
					st_d = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				ng_d = g_rd_q + 1'b1;
				dir_d = '0;
				st_d = ST_NB_RD;
			end
			ST_NB_RD: begin
				nb_d = cidx(nr, nc);
				g_ra = cidx(nr, nc);
				if (nb_ok) st_d = ST_NB_WR;
				else if (dir_q == 2'd3) begin
					cnt_d = '0; bestf_d = 8'hff; st_d = ST_SCAN;
				end else dir_d = dir_q + 1'b1;
			end
			ST_NB_WR: begin
				g_wa = nb_q;
				if (ng_q < g_rd_q) begin
					g_we = 1'b1; p_we = 1'b1; f_we = 1'b1;
					g_wd = ng_q;
					p_wd = {1'b0, cur_q};
					f_wd = ng_q + COST_W'(adist(nr, gr) + adist(nc, gcl));
					open_d[nb_q] = 1'b1;
				end
				if (dir_q == 2'd3) begin
					cnt_d = '0; bestf_d = 8'hff; st_d = ST_SCAN;
				end else begin
					dir_d = dir_q + 1'b1; st_d = ST_NB_RD;
				end
			end
			ST_TRACE_RD: begin
				g_ra = cur_q;
				s_we = 1'b1; s_wa = len_q[CELL_W-1:0]; s_wd = cur_q;
				len_d = len_q + 1'b1;
				if (cur_q == s_q || len_q == 7'd63) st_d = ST_EMIT_RD;
				else st_d = ST_TRACE_WAIT;
				cnt_d = '0;
			end
			ST_TRACE_WAIT: begin
				if (p_rd_q[COST_W-1]) st_d = ST_EMIT_RD;
				else begin
					cur_d = p_rd_q[CELL_W-1:0];
					st_d = ST_TRACE_RD;
				end
			end
			ST_EMIT_RD: begin
				s_ra = CELL_W'(len_q - 1'b1 - cnt_q);
				if (!ov_q || res.ready) st_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				ov_d = 1'b1; of_d = 1'b1;
				orow_d = crow(s_rd_q); ocol_d = ccol(s_rd_q);
				ostep_d = cnt_q[CELL_W-1:0];
				ol_d = (cnt_q + 1'b1 == len_q);
				cnt_d = cnt_q + 1'b1;
				st_d = (cnt_q + 1'b1 == len_q) ? ST_IDLE : ST_OUT;
			end
			ST_OUT: begin
				if (res.ready) st_d = ST_EMIT_RD;
			end
			default: st_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.step_index))
		else $error("result dropped while stalled");
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.found |-> res.last && res.step_index == 6'd0)
		else $error("failure result malformed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !req.ready)
		else $error("request taken while busy");
`endif
endmodule

/* sim/tb_grid_astar_path_search_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search_core
// Drives start/goal requests over a range of occupancy maps, predicts every
// path cell with an in-bench A* planner and checks each result in order.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search_core;
	import gap_pkg::*;

	localparam int unsigned SIDE       = 8;
	localparam int unsigned CELLS      = SIDE * SIDE;
	localparam logic [2:0]  MAP_ADDR   = 3'd0;   // passable_map, 64-bit register 0
	localparam int unsigned STALL_MAX  = 40000;  // cycles without any handshake
	localparam int unsigned HOLD_LEN   = 2500;   // long receiver hold-off
	localparam int unsigned DRAIN_WAIT = 100;

	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
		logic [5:0] step;
		logic       last;
	} path_cell_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	gap_req_if req ();
	gap_res_if res ();

	grid_astar_path_search_core #(.GRID_SIDE(SIDE)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Bench copy of the map register and the queue of predicted path cells
	logic [63:0] map_shadow;
	path_cell_t  path_q[$];
	int          errors;
	int          quiet_cycles;
	int          burst_left;
	int          hold_req;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Drive the reset, bus and request inputs to known values from time zero
	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req.valid     <= 1'b0;
		req.start_row <= '0;
		req.start_col <= '0;
		req.goal_row  <= '0;
		req.goal_col  <= '0;
	end

	function automatic bit cell_ok(input int r, input int c);
		if (r < 0 || c < 0 || r >= SIDE || c >= SIDE)
			return 1'b0;
		return map_shadow[r * SIDE + c];
	endfunction

	function automatic int manhattan(input int r, input int c, input int gr, input int gc);
		return ((r > gr) ? r - gr : gr - r) + ((c > gc) ? c - gc : gc - c);
	endfunction

	// Append one predicted path cell
	function automatic void queue_cell(input path_cell_t pc);
		path_q.insert(path_q.size(), pc);
	endfunction

	// A* with lowest-f, lowest-index selection; queues the predicted path cells
	function automatic void plan_path(input int sr, input int sc, input int gr, input int gc);
		int         gcost[CELLS];
		int         pred[CELLS];
		int         fcost[CELLS];
		int         trail[CELLS];
		bit [63:0]  open_mask;
		int         s, g, cur, best, bestf, cnt, nr, nc, n, ng;
		bit         reached;
		path_cell_t pc;
		for (int i = 0; i < CELLS; i++) begin
			gcost[i] = 127;
			pred[i]  = 127;
			fcost[i] = 0;
		end
		open_mask = '0;
		reached   = 1'b0;
		if (!cell_ok(sr, sc) || !cell_ok(gr, gc)) begin
			pc = '{found: 1'b0, row: 3'd0, col: 3'd0, step: 6'd0, last: 1'b1};
			queue_cell(pc);
			return;
		end
		s = sr * SIDE + sc;
		g = gr * SIDE + gc;
		gcost[s] = 0;
		fcost[s] = manhattan(sr, sc, gr, gc);
		open_mask[s] = 1'b1;
		while (open_mask != '0) begin
			best  = 0;
			bestf = 4096;
			for (int i = 0; i < CELLS; i++)
				if (open_mask[i] && fcost[i] < bestf) begin
					bestf = fcost[i];
					best  = i;
				end
			cur = best;
			if (cur == g) begin
				reached = 1'b1;
				break;
			end
			open_mask[cur] = 1'b0;
			ng = gcost[cur] + 1;
			// Neighbours in the order up, down, left, right
			for (int d = 0; d < 4; d++) begin
				nr = cur / SIDE + ((d == 0) ? -1 : (d == 1) ? 1 : 0);
				nc = cur % SIDE + ((d == 2) ? -1 : (d == 3) ? 1 : 0);
				if (!cell_ok(nr, nc))
					continue;
				n = nr * SIDE + nc;
				if (ng < gcost[n]) begin
					gcost[n]     = ng;
					pred[n]      = cur;
					fcost[n]     = ng + manhattan(nr, nc, gr, gc);
					open_mask[n] = 1'b1;
				end
			end
		end
		if (!reached) begin
			pc = '{found: 1'b0, row: 3'd0, col: 3'd0, step: 6'd0, last: 1'b1};
			queue_cell(pc);
			return;
		end
		cnt = 0;
		cur = g;
		while (cnt < CELLS) begin
			trail[cnt++] = cur;
			if (cur == s || pred[cur] >= CELLS)
				break;
			cur = pred[cur];
		end
		for (int k = 0; k < cnt; k++) begin
			pc.found = 1'b1;
			pc.row   = 3'(trail[cnt - 1 - k] / SIDE);
			pc.col   = 3'(trail[cnt - 1 - k] % SIDE);
			pc.step  = 6'(k);
			pc.last  = (k + 1 == cnt);
			queue_cell(pc);
		end
	endfunction

	// Drop the request line, wait for the core to drain, then write the map
	task automatic write_map(input logic [63:0] value);
		req.valid  <= 1'b0;
		burst_left = 0;
		wait (path_q.size() == 0);
		repeat (16) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= MAP_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		map_shadow = value;
	endtask

	// Offer one request; valid stays high into the next request of a burst
	task automatic send_request(input logic [2:0] sr, input logic [2:0] sc,
	                            input logic [2:0] gr, input logic [2:0] gc);
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 6);
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.start_row <= sr;
		req.start_col <= sc;
		req.goal_row  <= gr;
		req.goal_col  <= gc;
		do
			@(posedge clk);
		while (!req.ready);
		plan_path(sr, sc, gr, gc);
	endtask

	task automatic idle_request_line();
		req.valid  <= 1'b0;
		burst_left = 0;
	endtask

	// Pick a start or goal cell, mostly a passable one
	task automatic pick_cell(output logic [2:0] r, output logic [2:0] c);
		int tries;
		tries = 0;
		do begin
			r = 3'($urandom_range(0, 7));
			c = 3'($urandom_range(0, 7));
			tries++;
		end while (!map_shadow[r * SIDE + c] && tries < 40 && $urandom_range(0, 9) != 0);
	endtask

	task automatic test_open_grid();
		write_map('1);
		send_request(3'd0, 3'd0, 3'd7, 3'd7);
		send_request(3'd7, 3'd7, 3'd0, 3'd0);
		send_request(3'd0, 3'd7, 3'd7, 3'd0);
		send_request(3'd7, 3'd0, 3'd0, 3'd7);
		send_request(3'd5, 3'd2, 3'd5, 3'd2);   // start equals goal
		send_request(3'd3, 3'd4, 3'd4, 3'd3);
		idle_request_line();
	endtask

	task automatic test_blocked_ends();
		write_map('0);
		send_request(3'd0, 3'd0, 3'd7, 3'd7);
		send_request(3'd7, 3'd7, 3'd7, 3'd7);
		// Block the corners only: start blocked, then goal blocked
		write_map(64'hFFFF_FFFF_FFFF_FFFE & 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(3'd0, 3'd0, 3'd4, 3'd4);
		send_request(3'd4, 3'd4, 3'd7, 3'd7);
		send_request(3'd1, 3'd1, 3'd6, 3'd6);
		idle_request_line();
	endtask

	task automatic test_walls();
		// Full wall in column 4: no path across
		write_map(~64'h1010_1010_1010_1010);
		send_request(3'd2, 3'd1, 3'd5, 3'd6);
		send_request(3'd0, 3'd0, 3'd7, 3'd3);
		// Wall with a gap at the bottom forces a detour
		write_map(~64'h0010_1010_1010_1010);
		send_request(3'd0, 3'd3, 3'd0, 3'd5);
		send_request(3'd6, 3'd7, 3'd1, 3'd0);
		// Corridor pattern ORed with full rows: every cell ends up passable
		write_map(64'hFF80_FF01_FF80_FF01 | 64'h00FF_00FF_00FF_00FF);
		send_request(3'd0, 3'd0, 3'd7, 3'd7);
		send_request(3'd7, 3'd0, 3'd0, 3'd7);
		idle_request_line();
	endtask

	task automatic test_pressure();
		write_map('1);
		hold_req = HOLD_LEN;
		for (int i = 0; i < 6; i++)
			send_request(3'd0, 3'd0, 3'($urandom_range(4, 7)), 3'($urandom_range(4, 7)));
		idle_request_line();
	endtask

	task automatic test_random_maps();
		logic [63:0] m;
		logic [2:0]  sr, sc, gr, gc;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					m = {$urandom, $urandom} | {$urandom, $urandom};
				end
				1: begin
					m = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
				end
				2: begin
					m = {$urandom, $urandom};
				end
				default: begin
					m = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
				end
			endcase
			write_map(m);
			for (int i = 0; i < 42; i++) begin
				pick_cell(sr, sc);
				pick_cell(gr, gc);
				send_request(sr, sc, gr, gc);
			end
			idle_request_line();
		end
	endtask

	initial begin
		errors     = 0;
		map_shadow = '0;
		burst_left = 0;
		hold_req   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		test_open_grid();
		test_blocked_ends();
		test_walls();
		test_pressure();
		test_random_maps();
		wait (path_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: stall pattern of its own, plus a long hold-off on request
	int rx_mode;
	int rx_left;
	initial begin
		rx_mode = 0;
		rx_left = 0;
	end
	always @(posedge clk) begin
		if (hold_req > 0) begin
			res.ready <= 1'b0;
			hold_req  <= hold_req - 1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				0:       res.ready <= 1'b1;
				1:       res.ready <= $urandom_range(0, 1);
				default: res.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Compare each accepted path cell with the oldest prediction
	always @(posedge clk) begin
		path_cell_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{found: res.found, row: res.cell_row, col: res.cell_col,
			        step: res.step_index, last: res.last};
			if (path_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %p", $time, got);
			end else begin
				want = path_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: result mismatch, expected %p, actual %p",
					         $time, want, got);
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_MAX) begin
			$display("Regression FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end
endmodule
